>>> rtl/core/lzwc_pkg.sv
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared constants of the LZW byte compressor.
// ----------------------------------------------------------------------------
package lzwc_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CODE_W     = 12;
    localparam int unsigned FIRST_FREE = 256;

endpackage

>>> rtl/core/lzwc_ram.sv
// ----------------------------------------------------------------------------
// lzwc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lzwc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/lzw_byte_compressor.sv
// ----------------------------------------------------------------------------
// lzw_byte_compressor
// LZW compressor over bytes; emits dictionary codes, flags the last code.
// ----------------------------------------------------------------------------
// The first byte of a stream becomes the match code without a lookup. Every
// later byte hashes (match code, byte) into a slot table of 2*DICT_SIZE
// entries and probes it linearly; each probe is a slot read, then an entry
// read to check the key. A byte that ends the match emits a code, which
// may wait for the output register. After reset the block clears the slot
// table, one slot per cycle, with s_ready low. From then on a slot counts
// as live only when the code it holds is at least the first free code,
// below the next free code, and that entry points back to the slot, so a
// new stream starts with an empty dictionary at once and the entry RAM
// needs no clearing. A code waiting in the output register does not block
// the next input beat. When the dictionary is full it stops growing until
// the end of the stream.
module lzw_byte_compressor #(
    parameter int unsigned DICT_SIZE = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lzwc_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic                          s_end_of_stream,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lzwc_pkg::CODE_W-1:0]   m_dict_code,
    output logic                          m_final_code
);

    localparam int unsigned CW    = $clog2(DICT_SIZE);
    localparam int unsigned NW    = $clog2(DICT_SIZE + 1);
    localparam int unsigned SLOTS = 2 * DICT_SIZE;
    localparam int unsigned SW    = $clog2(SLOTS);
    localparam int unsigned BW    = lzwc_pkg::BYTE_W;
    localparam int unsigned EW    = CW + BW + SW;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_ENT,
        S_EMIT,
        S_FINAL
    } state_t;

    function automatic logic [SW-1:0] slot_hash(input logic [CW-1:0] p,
                                                input logic [BW-1:0] b);
        logic [SW-1:0] h;
        h = {p, 1'b0} ^ (SW'(b) << (SW - BW));
        if ({1'b0, h} >= (SW+1)'(SLOTS)) begin
            h = h - SW'(SLOTS);
        end
        return h;
    endfunction

    state_t            state_reg, state_next;
    logic [SW-1:0]     clr_reg, clr_next;
    logic [BW-1:0]     byte_reg, byte_next;
    logic              last_reg, last_next;
    logic [CW-1:0]     match_code_reg, match_code_next;
    logic              match_valid_reg, match_valid_next;
    logic [NW-1:0]     nfc_reg, nfc_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [CW-1:0]     cand_reg, cand_next;
    logic [CW-1:0]     emit_code_reg, emit_code_next;
    logic              m_valid_reg, m_valid_next;
    logic [lzwc_pkg::CODE_W-1:0] m_dict_code_reg, m_dict_code_next;
    logic              m_final_code_reg, m_final_code_next;

    logic [SW-1:0]     slot_inc;
    logic [SW-1:0]     slot_raddr;
    logic [CW-1:0]     slot_rdata;
    logic              clr_we;
    logic              slot_we;
    logic [SW-1:0]     slot_waddr;
    logic [CW-1:0]     slot_wdata;
    logic [EW-1:0]     entry_rdata;
    logic              ins_we;
    logic [CW-1:0]     e_prefix;
    logic [BW-1:0]     e_byte;
    logic [SW-1:0]     e_slot;
    logic              live;
    logic              out_free;

    assign slot_inc   = (slot_reg == SW'(SLOTS - 1)) ? '0 : slot_reg + 1'b1;
    assign slot_raddr = (state_reg == S_IDLE) ? slot_hash(match_code_reg, s_data_byte)
                                              : slot_inc;
    assign {e_prefix, e_byte, e_slot} = entry_rdata;
    assign live = (cand_reg >= CW'(lzwc_pkg::FIRST_FREE)) && (NW'(cand_reg) < nfc_reg)
                  && (e_slot == slot_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign ins_we = (state_reg == S_ENT) && !live && (nfc_reg < NW'(DICT_SIZE));

    assign clr_we     = (state_reg == S_CLEAR);
    assign slot_we    = ins_we || clr_we;
    assign slot_waddr = clr_we ? clr_reg : slot_reg;
    assign slot_wdata = clr_we ? '0 : nfc_reg[CW-1:0];

    lzwc_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    lzwc_ram #(.WIDTH(EW), .DEPTH(DICT_SIZE)) u_entry_ram (
        .aclk  (aclk),
        .we    (ins_we),
        .waddr (nfc_reg[CW-1:0]),
        .wdata ({match_code_reg, byte_reg, slot_reg}),
        .raddr (slot_rdata),
        .rdata (entry_rdata)
    );

    always_comb begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        byte_next         = byte_reg;
        last_next         = last_reg;
        match_code_next   = match_code_reg;
        match_valid_next  = match_valid_reg;
        nfc_next          = nfc_reg;
        slot_next         = slot_reg;
        cand_next         = cand_reg;
        emit_code_next    = emit_code_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_dict_code_next  = m_dict_code_reg;
        m_final_code_next = m_final_code_reg;
        case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SW'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    byte_next = s_data_byte;
                    last_next = s_end_of_stream;
                    if (!match_valid_reg) begin
                        match_code_next  = CW'(s_data_byte);
                        match_valid_next = 1'b1;
                        state_next       = s_end_of_stream ? S_FINAL : S_IDLE;
                    end else begin
                        slot_next  = slot_hash(match_code_reg, s_data_byte);
                        state_next = S_SLOT;
                    end
                end
            end
            S_SLOT: begin
                cand_next  = slot_rdata;
                state_next = S_ENT;
            end
            S_ENT: begin
                if (live) begin
                    if (e_prefix == match_code_reg && e_byte == byte_reg) begin
                        match_code_next = cand_reg;
                        state_next      = last_reg ? S_FINAL : S_IDLE;
                    end else begin
                        slot_next  = slot_inc;
                        state_next = S_SLOT;
                    end
                end else begin
                    emit_code_next  = match_code_reg;
                    match_code_next = CW'(byte_reg);
                    if (ins_we) begin
                        nfc_next = nfc_reg + 1'b1;
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_dict_code_next  = lzwc_pkg::CODE_W'(emit_code_reg);
                    m_final_code_next = 1'b0;
                    state_next        = last_reg ? S_FINAL : S_IDLE;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_dict_code_next  = lzwc_pkg::CODE_W'(match_code_reg);
                    m_final_code_next = 1'b1;
                    match_valid_next  = 1'b0;
                    match_code_next   = '0;
                    nfc_next          = NW'(lzwc_pkg::FIRST_FREE);
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            match_code_reg  <= '0;
            match_valid_reg <= 1'b0;
            nfc_reg         <= NW'(lzwc_pkg::FIRST_FREE);
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            match_code_reg  <= match_code_next;
            match_valid_reg <= match_valid_next;
            nfc_reg         <= nfc_next;
            m_valid_reg     <= m_valid_next;
        end
        byte_reg         <= byte_next;
        last_reg         <= last_next;
        slot_reg         <= slot_next;
        cand_reg         <= cand_next;
        emit_code_reg    <= emit_code_next;
        m_dict_code_reg  <= m_dict_code_next;
        m_final_code_reg <= m_final_code_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_dict_code  = m_dict_code_reg;
    assign m_final_code = m_final_code_reg;

    a_nfc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        nfc_reg >= NW'(lzwc_pkg::FIRST_FREE) && nfc_reg <= NW'(DICT_SIZE))
        else $error("next free code out of range");

    a_match_known: assert property (@(posedge aclk) disable iff (!aresetn)
        match_valid_reg |-> NW'(match_code_reg) < nfc_reg)
        else $error("match code not in dictionary");

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_we |=> nfc_reg == $past(nfc_reg) + 1'b1)
        else $error("insert did not advance next free code");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINAL && out_free) |=>
            !match_valid_reg && nfc_reg == NW'(lzwc_pkg::FIRST_FREE) && m_final_code_reg)
        else $error("end of stream did not restart dictionary");

endmodule

>>> bench/lzw_byte_compressor_test.sv
// ----------------------------------------------------------------------------
// lzw_byte_compressor_test
// Drives byte streams into the LZW compressor under random source gaps and
// sink stalls, predicts every emitted code with an independent dictionary
// model, and compares each output beat in order. Covers single-byte streams,
// repeated runs, an alternating pair, output back-pressure that stalls the
// input, and drains in the middle of a stream.
// ----------------------------------------------------------------------------
module lzw_byte_compressor_test;

    localparam int unsigned DICT_CODES  = 4096;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned SETTLE      = 64;
    localparam int unsigned RANDOM_BYTES = 420;

    typedef struct packed {
        logic [lzwc_pkg::CODE_W-1:0] code;
        logic                        last;
    } code_beat_t;

    logic                        aclk            = 1'b0;
    logic                        aresetn         = 1'b0;
    logic                        s_valid         = 1'b0;
    logic                        s_ready;
    logic [lzwc_pkg::BYTE_W-1:0] s_data_byte     = '0;
    logic                        s_end_of_stream = 1'b0;
    logic                        m_valid;
    logic                        m_ready         = 1'b0;
    logic [lzwc_pkg::CODE_W-1:0] m_dict_code;
    logic                        m_final_code;

    // expected codes in emission order
    code_beat_t        pending_codes[$];
    code_beat_t        want_beat;

    // dictionary model: {prefix code, byte} -> code
    logic [lzwc_pkg::CODE_W-1:0] code_of[bit [lzwc_pkg::CODE_W+lzwc_pkg::BYTE_W-1:0]];
    logic [12:0]                 next_code  = 13'(lzwc_pkg::FIRST_FREE);
    logic [lzwc_pkg::CODE_W-1:0] cur_match  = '0;
    bit                          match_held = 1'b0;

    int unsigned       errors      = 0;
    int unsigned       bytes_sent  = 0;
    int unsigned       cycle_count = 0;
    bit                tx_gaps_on  = 1'b1;
    bit                rx_stalls_on = 1'b1;
    int unsigned       hold_len    = 0;
    bit                hold_kick   = 1'b0;
    bit                hold_seen   = 1'b0;
    int unsigned       stall_left  = 0;

    lzw_byte_compressor DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_dict_code     (m_dict_code),
        .m_final_code    (m_final_code)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void predict_codes(logic [lzwc_pkg::BYTE_W-1:0] b, logic eos);
        bit [lzwc_pkg::CODE_W+lzwc_pkg::BYTE_W-1:0] key;
        key = {cur_match, b};
        if (!match_held) begin
            cur_match  = lzwc_pkg::CODE_W'(b);
            match_held = 1'b1;
        end else if (code_of.exists(key)) begin
            cur_match = code_of[key];
        end else begin
            pending_codes.push_back(code_beat_t'{code: cur_match, last: 1'b0});
            if (next_code < DICT_CODES) begin
                code_of[key] = next_code[lzwc_pkg::CODE_W-1:0];
                next_code    = next_code + 13'd1;
            end
            cur_match = lzwc_pkg::CODE_W'(b);
        end
        if (eos) begin
            pending_codes.push_back(code_beat_t'{code: cur_match, last: 1'b1});
            match_held = 1'b0;
            cur_match  = '0;
            next_code  = 13'(lzwc_pkg::FIRST_FREE);
            code_of.delete();
        end
    endfunction

    // sink: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
            hold_seen  <= hold_kick;
        end else if (hold_kick != hold_seen) begin
            hold_seen  <= hold_kick;
            stall_left <= hold_len;
            m_ready    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left <= pick_gap();
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_codes.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual code %0h last %0b",
                         $time, m_dict_code, m_final_code);
                errors++;
            end else begin
                want_beat = pending_codes.pop_front();
                if (m_dict_code !== want_beat.code) begin
                    $display("%0t: code expected %0h actual %0h",
                             $time, want_beat.code, m_dict_code);
                    errors++;
                end
                if (m_final_code !== want_beat.last) begin
                    $display("%0t: final_code expected %0b actual %0b",
                             $time, want_beat.last, m_final_code);
                    errors++;
                end
            end
        end
    end

    task automatic send_byte(input logic [lzwc_pkg::BYTE_W-1:0] b, input logic eos);
        int unsigned gap;
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_end_of_stream <= eos;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_codes(b, eos);
        bytes_sent++;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold the source idle until every expected beat is out
    task automatic drain_codes();
        s_valid <= 1'b0;
        wait (pending_codes.size() == 0);
        @(posedge aclk);
    endtask

    task automatic send_stream(input int unsigned len, input bit narrow);
        logic [lzwc_pkg::BYTE_W-1:0] pool[4];
        int unsigned                 pool_n;
        logic [lzwc_pkg::BYTE_W-1:0] b;
        pool_n = $urandom_range(1, 4);
        foreach (pool[i]) pool[i] = lzwc_pkg::BYTE_W'($urandom_range(0, 255));
        for (int unsigned i = 0; i < len; i++) begin
            b = narrow ? pool[2'($urandom_range(0, pool_n - 1))]
                       : lzwc_pkg::BYTE_W'($urandom_range(0, 255));
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic check_single_byte_streams();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    // a run of one value, twice: the second run must see a fresh dictionary
    task automatic check_repeated_runs();
        for (int unsigned r = 0; r < 2; r++) begin
            for (int unsigned i = 0; i < 7; i++) begin
                send_byte(8'hFF, i == 6);
            end
        end
    endtask

    task automatic check_alternating_pair();
        for (int unsigned i = 0; i < 7; i++) begin
            send_byte(i[0] ? 8'h42 : 8'h41, i == 6);
        end
        drain_codes();
    endtask

    task automatic check_output_backpressure();
        tx_gaps_on = 1'b0;
        hold_len   = 300;
        hold_kick  = ~hold_kick;
        send_stream(80, 1'b0);
        tx_gaps_on = 1'b1;
        drain_codes();
    endtask

    task automatic check_random_streams();
        int unsigned start;
        int unsigned len;
        int unsigned r;
        bit          narrow;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            tx_gaps_on   = r >= 20;
            rx_stalls_on = r >= 20;
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 120)
                                                 : $urandom_range(1, 30);
            narrow = $urandom_range(0, 9) < 7;
            send_stream(len, narrow);
            if ($urandom_range(0, 9) == 0) begin
                drain_codes();
            end
        end
        // pause inside a stream as well, then finish it
        send_stream(0, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        drain_codes();
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        drain_codes();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_single_byte_streams();
        check_repeated_runs();
        check_alternating_pair();
        check_output_backpressure();
        check_random_streams();

        rx_stalls_on = 1'b0;
        drain_codes();
        repeat (SETTLE) @(posedge aclk);

        if (errors == 0 && pending_codes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
